[rtl/csm_pkg.sv]
package csm_pkg;

    localparam int CH_W    = 8;
    localparam int PIX_W   = 32;
    localparam int LANES   = 4;
    localparam int W_W     = 12;
    localparam int SUM_W   = 10;
    localparam int NUM_W   = 23;
    localparam int DEN_W   = 15;
    localparam int CNT_W   = 3;
    localparam int Q_STEPS = 8;

    localparam logic [CH_W-1:0] CH_FULL = 8'hFF;

    typedef logic [CH_W-1:0] chan_t;

    typedef struct packed {
        logic             start;
        logic [W_W-1:0]   weight;
        logic [DEN_W-1:0] den;
        logic [3:0]       has;    // up, down, left, right from bit 0
    } csm_lane_ctl_t;

endpackage

[rtl/csm_lane.sv]
module csm_lane import csm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  csm_lane_ctl_t ctl,
    input  chan_t         centre,
    input  chan_t         up,
    input  chan_t         down,
    input  chan_t         left_px,
    input  chan_t         right_px,
    output logic          done,
    output chan_t         quot
);

    logic [SUM_W-1:0] sum;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] trial;
    logic             fits;

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    chan_t            quot_reg, quot_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb
    begin
        sum = (ctl.has[0] ? {2'b00, up} : '0) + (ctl.has[1] ? {2'b00, down} : '0)
            + (ctl.has[2] ? {2'b00, left_px} : '0) + (ctl.has[3] ? {2'b00, right_px} : '0);
        num = {7'd0, centre, 8'd0} + NUM_W'(ctl.weight * sum);
        trial = {{(NUM_W-DEN_W){1'b0}}, den_reg} << cnt_reg;
        fits = rem_reg >= trial;
        rem_next = fits ? rem_reg - trial : rem_reg;
        quot_next = quot_reg;
        quot_next[cnt_reg] = fits;
    end

    // restoring division, one quotient bit a cycle, MSB first
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
            busy_next = 1'b1;
        else if (busy_reg && cnt_reg == '0)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg  <= num;
            den_reg  <= ctl.den;
            cnt_reg  <= CNT_W'(Q_STEPS - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[rtl/csm_merge.sv]
module csm_merge import csm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [LANES*CH_W-1:0] lane_q,
    input  logic                  alpha_en,
    input  logic                  last,
    input  logic                  out_stall,
    output logic                  out_valid,
    output chan_t                 out_red,
    output chan_t                 out_green,
    output chan_t                 out_blue,
    output chan_t                 out_alpha,
    output logic                  frame_last
);

    logic  valid_reg, valid_next;
    chan_t red_reg, green_reg, blue_reg, alpha_reg;
    logic  last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (valid_reg && !out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= lane_q[0*CH_W +: CH_W];
            green_reg <= lane_q[1*CH_W +: CH_W];
            blue_reg  <= lane_q[2*CH_W +: CH_W];
            alpha_reg <= alpha_en ? lane_q[3*CH_W +: CH_W] : CH_FULL;
            last_reg  <= last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_red    = red_reg;
    assign out_green  = green_reg;
    assign out_blue   = blue_reg;
    assign out_alpha  = alpha_reg;
    assign frame_last = last_reg;

endmodule

[rtl/cross_kernel_pixel_smoother.sv]
// Steps from an accepted producing item to out_valid: line store read,
// divider load, eight bit-serial divider steps in each channel lane, result load.
// An item that yields a result holds in_stall high until that result is
// taken at the output; other items are accepted without a stall.
// Reset: rst_n asynchronous, clears counters and control; line stores are
// not cleared and hold nothing valid until written.
module cross_kernel_pixel_smoother import csm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  chan_t       in_red,
    input  chan_t       in_green,
    input  chan_t       in_blue,
    input  chan_t       in_alpha,
    output logic        out_valid,
    input  logic        out_stall,
    output chan_t       out_red,
    output chan_t       out_green,
    output chan_t       out_blue,
    output chan_t       out_alpha,
    output logic        frame_last
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WEIGHT = 2'd2;
    localparam logic [1:0] REG_ALPHA  = 2'd3;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [10:0]    width_reg;
    logic [12:0]    height_reg;
    logic [W_W-1:0] weight_reg;
    logic           alpha_reg;

    logic [1:0]    state_reg, state_next;
    logic [XW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          swap_reg, swap_next;
    logic          drain_reg, drain_next;

    logic [PIX_W-1:0] older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] older_x_reg, older_x1_reg, middle_x_reg, middle_x1_reg;
    logic [PIX_W-1:0] left_reg, pix_reg;
    logic             item_swap_reg, last_reg, last_next;
    logic [3:0]       has_reg, has_next;

    logic [31:0]      w_eff, h_eff, x_inc, row_inc, row32;
    logic [XW-1:0]    x_plus;
    logic             accept, pix_item, store_en, produce;
    logic [PIX_W-1:0] pix;

    logic [PIX_W-1:0] centre_w, up_w, right_w;
    logic [2:0]       n_count;
    csm_lane_ctl_t    lane_ctl;
    logic [LANES-1:0] lane_done;
    logic [LANES*CH_W-1:0] lane_q;
    logic             out_taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 13'd1024;
            weight_reg <= 12'd128;
            alpha_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[10:0];
                REG_HEIGHT: height_reg <= cfg_data;
                REG_WEIGHT: weight_reg <= cfg_data[W_W-1:0];
                REG_ALPHA:  alpha_reg  <= cfg_data[0];
                default:    alpha_reg  <= alpha_reg;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            w_eff = 32'd1;
        else if ({21'd0, width_reg} > MAX_WIDTH)
            w_eff = MAX_WIDTH;
        else
            w_eff = {21'd0, width_reg};
        if (height_reg == '0)
            h_eff = 32'd1;
        else if ({19'd0, height_reg} > MAX_HEIGHT)
            h_eff = MAX_HEIGHT;
        else
            h_eff = {19'd0, height_reg};
    end

    assign in_stall = state_reg != ST_IDLE;
    assign accept   = in_valid && !in_stall;
    assign pix_item = !req_type;
    assign pix      = {alpha_reg ? in_alpha : CH_FULL, in_blue, in_green, in_red};
    assign x_inc    = {{(32-XW){1'b0}}, col_reg} + 32'd1;
    assign row32    = {{(32-RW){1'b0}}, row_reg};
    assign row_inc  = row32 + 32'd1;
    assign x_plus   = x_inc[XW-1:0];
    assign store_en = accept && pix_item && !drain_reg;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        swap_next  = swap_reg;
        drain_next = drain_reg;
        produce    = 1'b0;
        last_next  = 1'b0;
        has_next   = '0;
        if (accept && pix_item && !drain_reg)
        begin
            produce  = row32 >= 32'd1;
            has_next = {x_inc < w_eff, col_reg != '0, 1'b1, row32 >= 32'd2};
            if (x_inc >= w_eff)
            begin
                col_next  = '0;
                swap_next = !swap_reg;
                if (row_inc >= h_eff)
                    drain_next = 1'b1;
                else
                    row_next = row_inc[RW-1:0];
            end
            else
                col_next = x_plus;
        end
        else if (accept && !pix_item && drain_reg)
        begin
            produce   = 1'b1;
            last_next = x_inc >= w_eff;
            has_next  = {x_inc < w_eff, col_reg != '0, 1'b0, row32 >= 32'd1};
            if (last_next)
            begin
                col_next   = '0;
                row_next   = '0;
                drain_next = 1'b0;
            end
            else
                col_next = x_plus;
        end
    end

    assign out_taken = out_valid && !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (produce) state_next = ST_READ;
            ST_READ: state_next = ST_DIV;
            ST_DIV:  if (lane_done[0]) state_next = ST_OUT;
            ST_OUT:  if (out_taken) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            swap_reg  <= 1'b0;
            drain_reg <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            swap_reg  <= swap_next;
            drain_reg <= drain_next;
            if (state_reg == ST_READ)
                left_reg <= centre_w;
        end
    end

    // read before write: the old row entry at x is read on the edge it is replaced
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            older_x_reg   <= older_mem[col_reg];
            older_x1_reg  <= older_mem[x_plus];
            middle_x_reg  <= middle_mem[col_reg];
            middle_x1_reg <= middle_mem[x_plus];
            pix_reg       <= pix;
            item_swap_reg <= swap_reg;
            has_reg       <= has_next;
            last_reg      <= last_next;
        end
        if (store_en && !swap_reg)
            older_mem[col_reg] <= pix;
        if (store_en && swap_reg)
            middle_mem[col_reg] <= pix;
    end

    always_comb
    begin
        centre_w = item_swap_reg ? older_x_reg  : middle_x_reg;
        right_w  = item_swap_reg ? older_x1_reg : middle_x1_reg;
        up_w     = item_swap_reg ? middle_x_reg : older_x_reg;
        n_count  = 3'(has_reg[0]) + 3'(has_reg[1]) + 3'(has_reg[2]) + 3'(has_reg[3]);
        lane_ctl.start  = state_reg == ST_READ;
        lane_ctl.weight = weight_reg;
        lane_ctl.den    = DEN_W'(256) + DEN_W'(weight_reg * n_count);
        lane_ctl.has    = has_reg;
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            csm_lane u_lane
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (lane_ctl),
                .centre   (centre_w[g*CH_W +: CH_W]),
                .up       (up_w[g*CH_W +: CH_W]),
                .down     (pix_reg[g*CH_W +: CH_W]),
                .left_px  (left_reg[g*CH_W +: CH_W]),
                .right_px (right_w[g*CH_W +: CH_W]),
                .done     (lane_done[g]),
                .quot     (lane_q[g*CH_W +: CH_W])
            );
        end
    endgenerate

    csm_merge u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (state_reg == ST_DIV && (&lane_done)),
        .lane_q     (lane_q),
        .alpha_en   (alpha_reg),
        .last       (last_reg),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .frame_last (frame_last)
    );

endmodule

[sim/csm_tb_pkg.sv]
`timescale 1ns / 100ps
package csm_tb_pkg;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WEIGHT = 2'd2;
    localparam logic [1:0] REG_ALPHA  = 2'd3;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam int ROW_MAX   = 1024;
    localparam int FRAME_MAX = 4096;

    function automatic int clamp_width(int v);
        v = v & 'h7FF;
        if (v == 0) return 1;
        return (v > ROW_MAX) ? ROW_MAX : v;
    endfunction

    function automatic int clamp_height(int v);
        v = v & 'h1FFF;
        if (v == 0) return 1;
        return (v > FRAME_MAX) ? FRAME_MAX : v;
    endfunction

endpackage

[sim/smoother_checker.sv]
`timescale 1ns / 100ps
module smoother_checker import csm_pkg::*, csm_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        req_type,
    input  chan_t       in_red,
    input  chan_t       in_green,
    input  chan_t       in_blue,
    input  chan_t       in_alpha,
    input  logic        out_valid,
    input  logic        out_stall,
    input  chan_t       out_red,
    input  chan_t       out_green,
    input  chan_t       out_blue,
    input  chan_t       out_alpha,
    input  logic        frame_last,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
        logic  last;
    } smoothed_t;

    smoothed_t smoothed_q[$];

    logic [31:0] row_a[ROW_MAX];
    logic [31:0] row_b[ROW_MAX];
    logic [31:0] left_pix;
    int          col, row;
    bit          swap, draining;

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [11:0] weight_reg;
    logic        alpha_reg;

    assign pending = smoothed_q.size();

    // mid = previous row, old = row before it
    function automatic logic [31:0] row_read(bit mid, int idx);
        bit take_b;
        take_b = swap ? !mid : mid;
        if (idx >= ROW_MAX) return 32'h0;
        return take_b ? row_b[idx] : row_a[idx];
    endfunction

    function automatic smoothed_t cross_blur(logic [31:0] centre, logic [31:0] nb[4],
                                             bit has[4], logic last);
        smoothed_t   res;
        int unsigned n, den, num, sum;
        chan_t       ch_out[4];
        n = 0;
        for (int i = 0; i < 4; i++)
            if (has[i]) n++;
        den = 256 + weight_reg * n;
        for (int c = 0; c < 4; c++)
        begin
            sum = 0;
            for (int i = 0; i < 4; i++)
                if (has[i]) sum += nb[i][c*8 +: 8];
            num = centre[c*8 +: 8] * 256 + weight_reg * sum;
            ch_out[c] = chan_t'(num / den);
        end
        res.red   = ch_out[0];
        res.green = ch_out[1];
        res.blue  = ch_out[2];
        res.alpha = alpha_reg ? ch_out[3] : CH_FULL;
        res.last  = last;
        return res;
    endfunction

    task automatic predict(logic kind, logic [31:0] pix);
        int          w, h;
        logic [31:0] centre;
        logic [31:0] nb[4];
        bit          has[4];
        logic        last;
        w = clamp_width(width_reg);
        h = clamp_height(height_reg);
        centre = row_read(1, col);
        nb[0] = row_read(0, col);
        nb[2] = left_pix;
        nb[3] = row_read(1, col + 1);
        has[2] = col >= 1;
        has[3] = col + 1 < w;
        if (kind == REQ_PIXEL)
        begin
            if (draining) return;
            if (row >= 1)
            begin
                nb[1] = pix;
                has[0] = row >= 2;
                has[1] = 1;
                smoothed_q.push_back(cross_blur(centre, nb, has, 1'b0));
                left_pix = centre;
            end
            if (col < ROW_MAX)
            begin
                if (swap) row_b[col] = pix;
                else      row_a[col] = pix;
            end
            if (col + 1 >= w)
            begin
                col = 0;
                swap = !swap;
                if (row + 1 >= h) draining = 1;
                else row++;
            end
            else
                col++;
        end
        else
        begin
            if (!draining) return;
            last = col + 1 >= w;
            nb[1] = 32'h0;
            has[0] = row >= 1;
            has[1] = 0;
            smoothed_q.push_back(cross_blur(centre, nb, has, last));
            left_pix = centre;
            if (last)
            begin
                col = 0;
                row = 0;
                draining = 0;
            end
            else
                col++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        smoothed_t   got, want;
        logic [31:0] pix;
        if (!rst_n)
        begin
            smoothed_q.delete();
            left_pix = 32'h0;
            col = 0;
            row = 0;
            swap = 0;
            draining = 0;
            width_reg = 11'd1024;
            height_reg = 13'd1024;
            weight_reg = 12'd128;
            alpha_reg = 1'b1;
            errors = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{out_red, out_green, out_blue, out_alpha, frame_last};
                if (smoothed_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected item r%h g%h b%h a%h l%b", $realtime,
                                 got.red, got.green, got.blue, got.alpha, got.last);
                end
                else
                begin
                    want = smoothed_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue || got.alpha !== want.alpha
                        || got.last !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch exp r%h g%h b%h a%h l%b got r%h g%h b%h a%h l%b",
                                     $realtime, want.red, want.green, want.blue, want.alpha,
                                     want.last, got.red, got.green, got.blue, got.alpha,
                                     got.last);
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_WIDTH:  width_reg = cfg_data[10:0];
                    REG_HEIGHT: height_reg = cfg_data[12:0];
                    REG_WEIGHT: weight_reg = cfg_data[11:0];
                    REG_ALPHA:  alpha_reg = cfg_data[0];
                    default:    ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                pix = {alpha_reg ? in_alpha : CH_FULL, in_blue, in_green, in_red};
                predict(req_type, pix);
            end
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
module tb;
    import csm_pkg::*;
    import csm_tb_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_WIDTH;
    logic [12:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = REQ_PIXEL;
    chan_t       in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    chan_t       out_red, out_green, out_blue, out_alpha;
    logic        frame_last;
    int          errors, pending;

    int  pixels_sent = 0;
    bit  sender_calm = 0;
    bit  receiver_calm = 0;
    bit  hold_long = 0;
    int  frame_w = 1024, frame_h = 1024;

    always #5 clk = ~clk;

    cross_kernel_pixel_smoother dut (.*);

    smoother_checker chk (.*);

    task automatic write_reg(logic [1:0] idx, int val);
        in_valid  <= 1'b0;
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 13'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic setup(int w, int h, int wt, bit al);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_WEIGHT, wt);
        write_reg(REG_ALPHA, al);
        frame_w = clamp_width(w);
        frame_h = clamp_height(h);
    endtask

    task automatic send(logic kind, chan_t r, chan_t g, chan_t b, chan_t a);
        int gap;
        in_valid <= 1'b1;
        req_type <= kind;
        in_red   <= r;
        in_green <= g;
        in_blue  <= b;
        in_alpha <= a;
        do @(posedge clk); while (in_stall);
        gap = sender_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_noise(logic kind);
        send(kind, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom),
             chan_t'($urandom));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (15) @(posedge clk);
    endtask

    // checker pattern when striped, otherwise random channels
    task automatic run_frame(bit striped, bit noisy);
        chan_t v;
        if (noisy) send_noise(REQ_DRAIN);
        for (int y = 0; y < frame_h; y++)
            for (int x = 0; x < frame_w; x++)
            begin
                if (noisy && $urandom_range(0, 15) == 0) send_noise(REQ_DRAIN);
                if (striped)
                begin
                    v = ((x + y) & 1) ? 8'hFF : 8'h00;
                    send(REQ_PIXEL, v, ~v, v, ~v);
                end
                else
                    send_noise(REQ_PIXEL);
                pixels_sent++;
            end
        if (noisy) send_noise(REQ_PIXEL);
        for (int x = 0; x < frame_w; x++)
        begin
            if (noisy && $urandom_range(0, 15) == 0) send_noise(REQ_PIXEL);
            send_noise(REQ_DRAIN);
            pixels_sent++;
        end
        wait_idle();
    endtask

    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            if (hold_long)
            begin
                hold_long = 0;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            else
            begin
                n = receiver_calm ? 0 : $urandom_range(0, 19);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        #10ms;
        $display("FAIL cross_kernel_pixel_smoother");
        $finish;
    end

    initial
    begin
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_noise(REQ_DRAIN);
        setup(0, 0, 4095, 1);
        run_frame(1, 0);
        setup(3, 3, 4095, 0);
        run_frame(1, 1);
        setup(2, 2, 0, 1);
        run_frame(1, 0);

        sender_calm = 1;
        setup(64, 4, 256, 1);
        hold_long = 1;
        run_frame(0, 0);
        setup(1, 40, 4095, 0);
        run_frame(0, 0);
        setup(100, 2, 17, 1);
        sender_calm = 0;
        run_frame(0, 0);

        pixels_sent = 0;
        while (pixels_sent < 700)
        begin
            case ($urandom_range(0, 3))
                0: n = 0;
                1: n = 4095;
                default: n = $urandom_range(0, 4095);
            endcase
            setup($urandom_range(1, 8), $urandom_range(1, 6), n, $urandom_range(0, 1));
            sender_calm = $urandom_range(0, 4) == 0;
            receiver_calm = $urandom_range(0, 4) == 0;
            run_frame(0, $urandom_range(0, 2) == 0);
        end

        wait_idle();
        if (errors == 0)
            $display("PASS cross_kernel_pixel_smoother");
        else
            $display("FAIL cross_kernel_pixel_smoother");
        $finish;
    end

endmodule
